// File: hw/rtl/tcsu_pkg.sv
`timescale 1ns / 1ps

package tcsu_pkg;

  localparam int PERIOD_W  = 16;
  localparam int VOLUME_W  = 6;
  localparam int CMD_W     = 5;
  localparam int PARAM_W   = 8;
  localparam int GVOL_W    = 7;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Effect letter codes.
  localparam logic [CMD_W-1:0] CMD_NONE = 5'd0;
  localparam logic [CMD_W-1:0] CMD_D    = 5'd4;
  localparam logic [CMD_W-1:0] CMD_E    = 5'd5;
  localparam logic [CMD_W-1:0] CMD_F    = 5'd6;
  localparam logic [CMD_W-1:0] CMD_G    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_L    = 5'd12;
  localparam logic [CMD_W-1:0] CMD_LAST = 5'd22;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_VOL  = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_LOW_RST  = 16'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_HIGH_RST = 16'd32767;
  localparam logic [GVOL_W-1:0]   GLOBAL_VOL_RST  = 7'd64;
  localparam logic [VOLUME_W-1:0] VOL_MAX         = 6'd63;

  // Volume slide sub-kinds (D and L).
  localparam logic [KIND_W-1:0] VK_DOWN      = 2'd0;
  localparam logic [KIND_W-1:0] VK_UP        = 2'd1;
  localparam logic [KIND_W-1:0] VK_FINE_DOWN = 2'd2;
  localparam logic [KIND_W-1:0] VK_FINE_UP   = 2'd3;

  // Pitch slide sub-kinds (E and F).
  localparam logic [KIND_W-1:0] PK_NORMAL = 2'd0;
  localparam logic [KIND_W-1:0] PK_FINE   = 2'd1;
  localparam logic [KIND_W-1:0] PK_EXTRA  = 2'd2;

  localparam logic [PARAM_W-1:0] NIB_HI_MASK = 8'hf0;
  localparam logic [PARAM_W-1:0] NIB_LO_MASK = 8'h0f;
  localparam logic [PARAM_W-1:0] EXTRA_BASE  = 8'he0;

  function automatic logic [KIND_W-1:0] vol_kind(input logic [PARAM_W-1:0] p);
    logic [KIND_W-1:0] k;
    if ((p & NIB_HI_MASK) == NIB_HI_MASK) begin
      k = (p == NIB_HI_MASK) ? VK_UP : VK_FINE_DOWN;
    end else if ((p & NIB_LO_MASK) == NIB_LO_MASK) begin
      k = (p == NIB_LO_MASK) ? VK_DOWN : VK_FINE_UP;
    end else begin
      k = ((p & NIB_LO_MASK) != '0) ? VK_DOWN : VK_UP;
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pitch_kind(input logic [PARAM_W-1:0] p);
    logic [KIND_W-1:0] k;
    if (p < EXTRA_BASE) begin
      k = PK_NORMAL;
    end else if (p < NIB_HI_MASK) begin
      k = PK_EXTRA;
    end else begin
      k = PK_FINE;
    end
    return k;
  endfunction

endpackage

// File: hw/rtl/tracker_channel_slide_unit.sv
`timescale 1ns / 1ps

// Slide effects of one tracker channel: volume slide, pitch slides and
// portamento.
//
// Input channel (in_valid / in_ready) takes one word per row or tick. A row
// word (mode 0) may load the channel period and volume and starts a new
// effect command; a tick word (mode 1) applies the effect in force.
// Result channel (out_valid / out_ready) returns one word per input word with
// the channel period, volume and the command in force.
//
// The result is registered: a word accepted at an edge shows its result after
// that edge. One word is taken per cycle while the receiver keeps up; the
// channel state registers double as the result register, so the whole update
// sits between them. While a result waits, in_ready follows out_ready, so a
// new word is taken in the same cycle that the waiting result leaves. When
// the receiver stalls the result holds and the input is held off.
//
// Reset clears the channel state and the result valid flag and loads the
// period bounds and the global volume with their defaults. The configuration
// port writes a register at every edge where cfg_we is high.
module tracker_channel_slide_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcsu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcsu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [tcsu_pkg::CMD_W-1:0]       in_command,
  input  logic [tcsu_pkg::PARAM_W-1:0]     in_param,
  input  logic                             in_load_period,
  input  logic [tcsu_pkg::PERIOD_W-1:0]    in_period_value,
  input  logic                             in_load_volume,
  input  logic [tcsu_pkg::VOLUME_W-1:0]    in_volume_value,
  input  logic [tcsu_pkg::PERIOD_W-1:0]    in_target_period,
  input  logic                             in_channel_active,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tcsu_pkg::PERIOD_W-1:0]    out_period_out,
  output logic [tcsu_pkg::VOLUME_W-1:0]    out_volume_out,
  output logic [tcsu_pkg::CMD_W-1:0]       out_active_command
);

  localparam int PW = tcsu_pkg::PERIOD_W;
  localparam int VW = tcsu_pkg::VOLUME_W;
  localparam int XW = PW + 2;  // signed width for period arithmetic

  // Configuration registers.
  logic [PW-1:0]                   period_low_r;
  logic [PW-1:0]                   period_high_r;
  logic [tcsu_pkg::GVOL_W-1:0]     global_volume_r;

  // Channel state; it is also what the result port shows.
  logic [tcsu_pkg::PARAM_W-1:0]    saved_param_r, saved_param_nxt;
  logic [tcsu_pkg::PARAM_W-1:0]    porta_speed_r, porta_speed_nxt;
  logic [tcsu_pkg::KIND_W-1:0]     slide_kind_r, slide_kind_nxt;
  logic [tcsu_pkg::CMD_W-1:0]      current_effect_r, current_effect_nxt;
  logic [PW-1:0]                   chan_period_r, chan_period_nxt;
  logic [VW-1:0]                   chan_volume_r, chan_volume_nxt;
  logic                            out_valid_r;

  logic                            in_accept;

  // Clamp a period result to the bounds; exactly zero means silent.
  function automatic logic [PW-1:0] put_period(input logic signed [XW-1:0] v,
                                               input logic [PW-1:0] lo,
                                               input logic [PW-1:0] hi);
    logic signed [XW-1:0] lo_s;
    logic signed [XW-1:0] hi_s;
    logic [PW-1:0]        r;
    lo_s = $signed({2'b00, lo});
    hi_s = $signed({2'b00, hi});
    if (v == '0) begin
      r = '0;
    end else if (v < lo_s) begin
      r = lo;
    end else if (v > hi_s) begin
      r = hi;
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    logic [tcsu_pkg::PARAM_W-1:0] p_use;
    logic signed [VW:0]           vol_dn;
    logic [VW:0]                  vol_sum;
    logic [VW+tcsu_pkg::GVOL_W:0] vol_prod;
    logic [VW+1:0]                vol_up;
    logic [VW-1:0]                vol_tick;
    logic signed [XW-1:0]         cur_p;
    logic signed [XW-1:0]         dst_p;
    logic signed [XW-1:0]         step_e;
    logic signed [XW-1:0]         porta_s;
    logic signed [XW-1:0]         porta_p;
    logic [PW-1:0]                porta_res;

    saved_param_nxt    = saved_param_r;
    porta_speed_nxt    = porta_speed_r;
    slide_kind_nxt     = slide_kind_r;
    current_effect_nxt = current_effect_r;
    chan_period_nxt    = chan_period_r;
    chan_volume_nxt    = chan_volume_r;

    p_use = (in_param != '0) ? in_param : saved_param_r;

    // Volume slide of a tick, from the saved parameter nibbles.
    vol_dn   = $signed({1'b0, chan_volume_r}) -
               $signed({3'b000, saved_param_r[3:0]});
    vol_sum  = {1'b0, chan_volume_r} + {3'b000, saved_param_r[7:4]};
    vol_prod = {{tcsu_pkg::GVOL_W{1'b0}}, vol_sum} *
               {{(VW+1){1'b0}}, global_volume_r};
    vol_up   = vol_prod[VW+tcsu_pkg::GVOL_W:6];
    case (slide_kind_r)
      tcsu_pkg::VK_DOWN: begin
        vol_tick = vol_dn[VW] ? '0 : vol_dn[VW-1:0];
      end
      tcsu_pkg::VK_UP: begin
        vol_tick = (vol_up > {2'b00, tcsu_pkg::VOL_MAX}) ? tcsu_pkg::VOL_MAX
                                                          : vol_up[VW-1:0];
      end
      default: begin
        vol_tick = chan_volume_r;
      end
    endcase

    // Pitch slide step and portamento toward the target, never passing it.
    cur_p   = $signed({2'b00, chan_period_r});
    dst_p   = $signed({2'b00, in_target_period});
    step_e  = $signed({8'd0, saved_param_r, 2'b00});
    porta_s = $signed({8'd0, porta_speed_r, 2'b00});
    if (cur_p > dst_p) begin
      porta_p = cur_p - porta_s;
      if (porta_p < dst_p) begin
        porta_p = dst_p;
      end
    end else begin
      porta_p = cur_p + porta_s;
      if (porta_p > dst_p) begin
        porta_p = dst_p;
      end
    end
    porta_res = put_period(porta_p, period_low_r, period_high_r);

    if (!in_mode) begin
      if (in_load_period) begin
        chan_period_nxt = in_period_value;
      end
      if (in_load_volume) begin
        chan_volume_nxt = in_volume_value;
      end
      if (in_command > tcsu_pkg::CMD_LAST) begin
        current_effect_nxt = tcsu_pkg::CMD_NONE;
      end else begin
        if (in_param != '0) begin
          saved_param_nxt = in_param;
        end
        current_effect_nxt = in_command;
        case (in_command)
          tcsu_pkg::CMD_D, tcsu_pkg::CMD_L: begin
            slide_kind_nxt = tcsu_pkg::vol_kind(p_use);
          end
          tcsu_pkg::CMD_E, tcsu_pkg::CMD_F: begin
            slide_kind_nxt = tcsu_pkg::pitch_kind(p_use);
          end
          tcsu_pkg::CMD_G: begin
            if (in_param != '0) begin
              porta_speed_nxt = in_param;
            end
            // Portamento on a silent channel is dropped at once.
            if (!in_channel_active) begin
              current_effect_nxt = tcsu_pkg::CMD_NONE;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      case (current_effect_r)
        tcsu_pkg::CMD_D: begin
          chan_volume_nxt = vol_tick;
        end
        tcsu_pkg::CMD_E: begin
          if (slide_kind_r == tcsu_pkg::PK_NORMAL) begin
            chan_period_nxt = put_period(cur_p + step_e, period_low_r, period_high_r);
          end
        end
        tcsu_pkg::CMD_F: begin
          if (slide_kind_r == tcsu_pkg::PK_NORMAL) begin
            chan_period_nxt = put_period(cur_p - step_e, period_low_r, period_high_r);
          end
        end
        tcsu_pkg::CMD_G: begin
          chan_period_nxt = porta_res;
        end
        tcsu_pkg::CMD_L: begin
          // The volume slide does not touch the period, so both apply at once.
          chan_volume_nxt = vol_tick;
          chan_period_nxt = porta_res;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_low_r    <= tcsu_pkg::PERIOD_LOW_RST;
      period_high_r   <= tcsu_pkg::PERIOD_HIGH_RST;
      global_volume_r <= tcsu_pkg::GLOBAL_VOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcsu_pkg::REG_PERIOD_LOW:  period_low_r    <= cfg_data;
        tcsu_pkg::REG_PERIOD_HIGH: period_high_r   <= cfg_data;
        tcsu_pkg::REG_GLOBAL_VOL:  global_volume_r <= cfg_data[tcsu_pkg::GVOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_param_r    <= '0;
      porta_speed_r    <= '0;
      slide_kind_r     <= '0;
      current_effect_r <= tcsu_pkg::CMD_NONE;
      chan_period_r    <= '0;
      chan_volume_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        saved_param_r    <= saved_param_nxt;
        porta_speed_r    <= porta_speed_nxt;
        slide_kind_r     <= slide_kind_nxt;
        current_effect_r <= current_effect_nxt;
        chan_period_r    <= chan_period_nxt;
        chan_volume_r    <= chan_volume_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_period_out     = chan_period_r;
  assign out_volume_out     = chan_volume_r;
  assign out_active_command = current_effect_r;

endmodule

// File: hw/rtl/tcsu_checker.sv
`timescale 1ns / 1ps

module tcsu_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tcsu_pkg::PERIOD_W-1:0]  out_period_out,
  input logic [tcsu_pkg::VOLUME_W-1:0]  out_volume_out,
  input logic [tcsu_pkg::CMD_W-1:0]     out_active_command
);

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A waiting result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_out) &&
      $stable(out_volume_out) && $stable(out_active_command))
    else $error("stalled result changed");

  // Input is taken only when the result stage is free or draining.
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the result stage");

  // Every accepted word yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // Commands beyond the last letter are never kept in force.
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_active_command <= tcsu_pkg::CMD_LAST)
    else $error("command in force out of range");

endmodule

bind tracker_channel_slide_unit tcsu_checker u_tcsu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_period_out     (out_period_out),
  .out_volume_out     (out_volume_out),
  .out_active_command (out_active_command)
);

// File: test/slide_checker.sv
`timescale 1ns / 1ps

package slide_tb_pkg;

  // Input word modes.
  localparam logic MODE_ROW  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

module slide_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tcsu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcsu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_mode,
  input  logic [tcsu_pkg::CMD_W-1:0]       in_command,
  input  logic [tcsu_pkg::PARAM_W-1:0]     in_param,
  input  logic                             in_load_period,
  input  logic [tcsu_pkg::PERIOD_W-1:0]    in_period_value,
  input  logic                             in_load_volume,
  input  logic [tcsu_pkg::VOLUME_W-1:0]    in_volume_value,
  input  logic [tcsu_pkg::PERIOD_W-1:0]    in_target_period,
  input  logic                             in_channel_active,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [tcsu_pkg::PERIOD_W-1:0]    out_period_out,
  input  logic [tcsu_pkg::VOLUME_W-1:0]    out_volume_out,
  input  logic [tcsu_pkg::CMD_W-1:0]       out_active_command,
  output int                               mismatches,
  output int                               outstanding,
  output int                               results_checked
);

  import tcsu_pkg::*;
  import slide_tb_pkg::*;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [VOLUME_W-1:0] volume;
    logic [CMD_W-1:0]    command;
  } chan_result_t;

  logic [PERIOD_W-1:0] bound_lo;
  logic [PERIOD_W-1:0] bound_hi;
  logic [GVOL_W-1:0]   master_vol;
  logic [PARAM_W-1:0]  last_param;
  logic [PARAM_W-1:0]  glide_speed;
  logic [KIND_W-1:0]   slide_sub;
  logic [CMD_W-1:0]    effect_now;
  logic [PERIOD_W-1:0] ch_period;
  logic [VOLUME_W-1:0] ch_volume;

  chan_result_t pending_results[$];

  // Zero means silent and passes through; anything else is held to the bounds.
  // When the bounds are crossed, the low bound wins unless the value reaches it.
  function automatic logic [PERIOD_W-1:0] bounded_period(input int v);
    if (v == 0) return '0;
    if (v < int'(bound_lo)) return bound_lo;
    if (v > int'(bound_hi)) return bound_hi;
    return v[PERIOD_W-1:0];
  endfunction

  function automatic logic [KIND_W-1:0] volume_slide_sub(input logic [PARAM_W-1:0] p);
    logic [3:0] up_nib;
    logic [3:0] dn_nib;
    up_nib = p[7:4];
    dn_nib = p[3:0];
    if (up_nib == 4'hf) return (dn_nib == 4'h0) ? VK_UP : VK_FINE_DOWN;
    if (dn_nib == 4'hf) return (up_nib == 4'h0) ? VK_DOWN : VK_FINE_UP;
    return (dn_nib != 4'h0) ? VK_DOWN : VK_UP;
  endfunction

  function automatic logic [KIND_W-1:0] pitch_slide_sub(input logic [PARAM_W-1:0] p);
    if (p < EXTRA_BASE) return PK_NORMAL;
    if (p < NIB_HI_MASK) return PK_EXTRA;
    return PK_FINE;
  endfunction

  task automatic slide_volume();
    int v;
    if (slide_sub == VK_DOWN) begin
      v = int'(ch_volume) - int'(last_param[3:0]);
      ch_volume = (v < 0) ? '0 : v[VOLUME_W-1:0];
    end else if (slide_sub == VK_UP) begin
      v = ((int'(ch_volume) + int'(last_param[7:4])) * int'(master_vol)) >> 6;
      ch_volume = (v > int'(VOL_MAX)) ? VOL_MAX : v[VOLUME_W-1:0];
    end
  endtask

  task automatic glide_toward(input logic [PERIOD_W-1:0] dest);
    int p;
    int d;
    int s;
    p = int'(ch_period);
    d = int'(dest);
    s = int'(glide_speed) * 4;
    if (p > d) begin
      p = p - s;
      if (p < d) p = d;
    end else begin
      p = p + s;
      if (p > d) p = d;
    end
    ch_period = bounded_period(p);
  endtask

  task automatic step_channel(output chan_result_t r);
    logic [PARAM_W-1:0] p;
    if (in_mode == MODE_ROW) begin
      if (in_load_period) ch_period = in_period_value;
      if (in_load_volume) ch_volume = in_volume_value;
      if (in_command > CMD_LAST) begin
        effect_now = CMD_NONE;
      end else begin
        p = (in_param != '0) ? in_param : last_param;
        if (in_param != '0) last_param = in_param;
        effect_now = in_command;
        if (in_command == CMD_D || in_command == CMD_L) begin
          slide_sub = volume_slide_sub(p);
        end else if (in_command == CMD_E || in_command == CMD_F) begin
          slide_sub = pitch_slide_sub(p);
        end else if (in_command == CMD_G) begin
          if (in_param != '0) glide_speed = in_param;
          if (!in_channel_active) effect_now = CMD_NONE;
        end
      end
    end else begin
      case (effect_now)
        CMD_D: begin
          slide_volume();
        end
        CMD_E: begin
          if (slide_sub == PK_NORMAL)
            ch_period = bounded_period(int'(ch_period) + int'(last_param) * 4);
        end
        CMD_F: begin
          if (slide_sub == PK_NORMAL)
            ch_period = bounded_period(int'(ch_period) - int'(last_param) * 4);
        end
        CMD_G: begin
          glide_toward(in_target_period);
        end
        CMD_L: begin
          slide_volume();
          glide_toward(in_target_period);
        end
        default: begin
        end
      endcase
    end
    r.period  = ch_period;
    r.volume  = ch_volume;
    r.command = effect_now;
  endtask

  initial begin
    mismatches      = 0;
    results_checked = 0;
    outstanding     = 0;
  end

  always @(posedge clk) begin : watch
    chan_result_t got;
    chan_result_t want;
    if (!rst_n) begin
      bound_lo    = PERIOD_LOW_RST;
      bound_hi    = PERIOD_HIGH_RST;
      master_vol  = GLOBAL_VOL_RST;
      last_param  = '0;
      glide_speed = '0;
      slide_sub   = '0;
      effect_now  = CMD_NONE;
      ch_period   = '0;
      ch_volume   = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD_LOW:  bound_lo = cfg_data;
          REG_PERIOD_HIGH: bound_hi = cfg_data;
          REG_GLOBAL_VOL:  master_vol = cfg_data[GVOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        got.period  = out_period_out;
        got.volume  = out_volume_out;
        got.command = out_active_command;
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result word with none expected, expected nothing actual %h/%h/%h",
                   $time, got.period, got.volume, got.command);
        end else begin
          want = pending_results.pop_front();
          if (got.period !== want.period) begin
            mismatches++;
            $display("%0t: period_out expected %h actual %h", $time, want.period, got.period);
          end
          if (got.volume !== want.volume) begin
            mismatches++;
            $display("%0t: volume_out expected %h actual %h", $time, want.volume, got.volume);
          end
          if (got.command !== want.command) begin
            mismatches++;
            $display("%0t: active_command expected %h actual %h",
                     $time, want.command, got.command);
          end
        end
      end
      if (in_valid && in_ready) begin
        step_channel(want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Top of the slide unit bench. This module only makes stimulus and gives the
// verdict; the checker beside the block watches both channels, keeps its own
// copy of the channel state and compares every result word in order.
module testbench;

  import tcsu_pkg::*;
  import slide_tb_pkg::*;

  // Watchdog limit; the slowest correct run stays well under it.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the deliberate receiver hold-off, long enough to back up the
  // single result register and stall the input.
  localparam int LONG_HOLD   = 64;
  localparam int PHASE_WORDS = 330;

  typedef struct packed {
    logic                mode;
    logic [CMD_W-1:0]    command;
    logic [PARAM_W-1:0]  param;
    logic                load_period;
    logic [PERIOD_W-1:0] period_value;
    logic                load_volume;
    logic [VOLUME_W-1:0] volume_value;
    logic [PERIOD_W-1:0] target_period;
    logic                channel_active;
  } chan_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [CMD_W-1:0]      in_command;
  logic [PARAM_W-1:0]    in_param;
  logic                  in_load_period;
  logic [PERIOD_W-1:0]   in_period_value;
  logic                  in_load_volume;
  logic [VOLUME_W-1:0]   in_volume_value;
  logic [PERIOD_W-1:0]   in_target_period;
  logic                  in_channel_active;
  logic                  out_valid;
  logic                  out_ready;
  logic [PERIOD_W-1:0]   out_period_out;
  logic [VOLUME_W-1:0]   out_volume_out;
  logic [CMD_W-1:0]      out_active_command;

  int mismatches;
  int outstanding;
  int results_checked;
  int rows_sent  = 0;
  int ticks_sent = 0;
  int cycle_count = 0;

  // When set, neither side inserts idle cycles, so the block runs at full
  // rate for a while. The stimulus flips it now and then.
  bit no_gaps = 1'b0;

  logic [CMD_W-1:0] slide_cmds [5] = '{CMD_D, CMD_E, CMD_F, CMD_G, CMD_L};

  tracker_channel_slide_unit u_dut (.*);

  slide_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tracker_channel_slide_unit verification failed");
    $finish;
  end

  // Result side. Before each word it draws a random idle stretch and then
  // keeps ready high until a word is taken. Twice in the run it holds ready
  // low for a long stretch while the sender keeps offering words, so the
  // block fills up and has to push back on its input.
  initial begin : result_side
    int gap;
    int taken;
    taken = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 500 || taken == 1300) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Offers one word after a random idle stretch and returns at the edge where
  // it is taken. Valid is left high, so back-to-back words keep it up and
  // only the payload changes.
  task automatic offer_word(input chan_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode           <= w.mode;
    in_command        <= w.command;
    in_param          <= w.param;
    in_load_period    <= w.load_period;
    in_period_value   <= w.period_value;
    in_load_volume    <= w.load_volume;
    in_volume_value   <= w.volume_value;
    in_target_period  <= w.target_period;
    in_channel_active <= w.channel_active;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (w.mode == MODE_ROW) rows_sent++;
    else ticks_sent++;
  endtask

  // Periods are mostly kept small so that the bounds and the portamento
  // target come into play, with zero and the full range now and then.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return PERIOD_W'($urandom_range(0, 65535));
    if (pick < 15) return '0;
    return PERIOD_W'($urandom_range(1, 4000));
  endfunction

  task automatic send_row(input logic [CMD_W-1:0] cmd, input logic [PARAM_W-1:0] prm,
                          input logic lp, input logic [PERIOD_W-1:0] pv,
                          input logic lv, input logic [VOLUME_W-1:0] vv, input logic act);
    chan_word_t w;
    w.mode           = MODE_ROW;
    w.command        = cmd;
    w.param          = prm;
    w.load_period    = lp;
    w.period_value   = pv;
    w.load_volume    = lv;
    w.volume_value   = vv;
    w.target_period  = pick_period();
    w.channel_active = act;
    offer_word(w);
  endtask

  // A tick only looks at the target period; everything else is noise.
  task automatic send_tick(input logic [PERIOD_W-1:0] target);
    chan_word_t w;
    w = chan_word_t'({$urandom, $urandom});
    w.mode          = MODE_TICK;
    w.target_period = target;
    offer_word(w);
  endtask

  task automatic random_row();
    logic [CMD_W-1:0]   cmd;
    logic [PARAM_W-1:0] prm;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) cmd = slide_cmds[$urandom_range(0, 4)];
    else if (pick < 90) cmd = CMD_W'($urandom_range(0, int'(CMD_LAST)));
    else cmd = CMD_W'($urandom_range(int'(CMD_LAST) + 1, 31));
    // Zero recalls the stored parameter; the nibble patterns pick the slide
    // flavors (plain up and down, fine, extra).
    pick = $urandom_range(0, 99);
    if (pick < 25) prm = '0;
    else if (pick < 30) prm = NIB_HI_MASK;
    else if (pick < 35) prm = NIB_LO_MASK;
    else if (pick < 40) prm = {4'hf, 4'($urandom)};
    else if (pick < 45) prm = {4'($urandom), 4'hf};
    else if (pick < 50) prm = {4'he, 4'($urandom)};
    else prm = PARAM_W'($urandom);
    send_row(cmd, prm, 1'($urandom_range(0, 1)), pick_period(), $urandom_range(0, 4) < 2,
             VOLUME_W'($urandom), $urandom_range(0, 99) < 85);
  endtask

  // Mostly a row followed by a few ticks, which is how a tracker drives the
  // unit; about one pass in ten sends a single fully random word instead.
  task automatic random_stretch(input int goal);
    chan_word_t w;
    int sent;
    int n;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 9) == 0) begin
        w = chan_word_t'({$urandom, $urandom});
        offer_word(w);
        sent++;
      end else begin
        random_row();
        n = $urandom_range(1, 6);
        repeat (n) send_tick(pick_period());
        sent += n + 1;
      end
    end
  endtask

  // Drops valid and waits until every expected result has come back, so that
  // the registers can be rewritten safely.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [PERIOD_W-1:0] lo, input logic [PERIOD_W-1:0] hi,
                                input logic [GVOL_W-1:0] gv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PERIOD_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_PERIOD_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_GLOBAL_VOL;
    cfg_data  <= CFG_DATA_W'(gv);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    // Register settings after the reset defaults: the widest bounds with the
    // volume multiplier at zero, a narrow window, crossed bounds with the
    // multiplier at its largest, and the defaults written back.
    logic [PERIOD_W-1:0] lo_set [4] = '{16'd1, 16'd1000, 16'hffff, PERIOD_LOW_RST};
    logic [PERIOD_W-1:0] hi_set [4] = '{16'hffff, 16'd3000, 16'd1, PERIOD_HIGH_RST};
    logic [GVOL_W-1:0]   gv_set [4] = '{7'd0, 7'd32, 7'h7f, GLOBAL_VOL_RST};
    int ph;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    in_mode           <= MODE_ROW;
    in_command        <= CMD_NONE;
    in_param          <= '0;
    in_load_period    <= 1'b0;
    in_period_value   <= '0;
    in_load_volume    <= 1'b0;
    in_volume_value   <= '0;
    in_target_period  <= '0;
    in_channel_active <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset defaults.
    // A tick with nothing in force changes nothing.
    send_tick(16'h0000);
    // Zero parameter with an empty memory decodes as a slide up by nothing.
    send_row(CMD_D, 8'h00, 1'b1, 16'd1000, 1'b1, 6'd10, 1'b1);
    send_tick(16'hffff);
    // Plain slide down by 15 from the top volume.
    send_row(CMD_D, NIB_LO_MASK, 1'b0, 16'd0, 1'b1, VOL_MAX, 1'b1);
    send_tick(16'd0);
    // Plain slide up by 15 runs into the volume cap.
    send_row(CMD_D, NIB_HI_MASK, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    send_tick(16'd0);
    // Fine down and fine up leave the volume alone on a tick; the L tick
    // still runs its portamento, here at the reset speed of zero.
    send_row(CMD_D, 8'hf3, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    send_row(CMD_L, 8'h3f, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    send_tick(16'd1200);
    // Portamento on a silent channel is dropped but still keeps its speed.
    send_row(CMD_G, 8'h10, 1'b0, 16'd0, 1'b0, 6'd0, 1'b0);
    send_tick(16'd1200);
    // Zero parameter keeps that speed; the second tick lands on the target.
    send_row(CMD_G, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    send_tick(16'd1100);
    send_tick(16'd1070);
    // Extra pitch slide does nothing on a tick.
    send_row(CMD_E, 8'he5, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    // Slide down past the top bound from the largest period.
    send_row(CMD_E, 8'hdf, 1'b1, 16'hffff, 1'b0, 6'd0, 1'b1);
    send_tick(16'd0);
    // Slide up below zero ends at the low bound.
    send_row(CMD_F, 8'h80, 1'b1, 16'd100, 1'b0, 6'd0, 1'b1);
    send_tick(16'd0);
    // Slide up to exactly zero leaves the channel silent.
    send_row(CMD_F, 8'h19, 1'b1, 16'd100, 1'b0, 6'd0, 1'b1);
    send_tick(16'd0);
    // Commands past the last one clear the effect and keep the memory.
    send_row('1, 8'haa, 1'b0, 16'd0, 1'b1, 6'd0, 1'b1);
    send_row(CMD_LAST + 5'd1, 8'h55, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    // Recall of the kept parameter slides down, floored at zero volume.
    send_row(CMD_D, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0, 1'b1);
    send_tick(16'd0);
    random_stretch(300);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      apply_settings(lo_set[ph], hi_set[ph], gv_set[ph]);
      random_stretch(PHASE_WORDS);
      drain();
    end

    $display("Sent %0d row words and %0d tick words under five register settings,",
             rows_sent, ticks_sent);
    $display("crossed bounds included; %0d results compared, with two long result stalls.",
             results_checked);
    if (mismatches == 0) begin
      $display("tracker_channel_slide_unit verification clean");
    end else begin
      $display("tracker_channel_slide_unit verification failed");
    end
    $finish;
  end

endmodule
